FILE: design/smft_pkg.sv
// Shared types and constants of the sparse matrix fast transpose unit.
// Depends on nothing; the top level imports it.
package smft_pkg;

    // Fixed field widths of the transfer payloads
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    // Defaults of the top-level parameters
    localparam int MAX_TERMS_DEF   = 64;
    localparam int MAX_DIM_DEF     = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // Reset value of both size registers
    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    // Command codes
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } cfg_reg_t;

    // Input item
    typedef struct packed {
        cmd_t                      cmd;
        logic [IDX_W-1:0]          src_row;
        logic [IDX_W-1:0]          src_col;
        logic signed [VALUE_W-1:0] term_value;
    } term_item_t;

    // Result item
    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [VALUE_W-1:0] out_value;
        logic                      has_term;
        logic                      is_last;
        logic [COUNT_W-1:0]        term_count;
        logic                      dropped;
    } result_item_t;

    // Sequencer states of the finish run
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PFX,
        ST_PL_TERM,
        ST_PL_COL,
        ST_PL_WR,
        ST_EM_ORD,
        ST_EM_TERM,
        ST_EM_OUT,
        ST_EMPTY
    } fst_t;

endpackage

FILE: design/sparse_matrix_fast_transpose_unit.sv
// Sparse matrix fast transpose: term store, per-column count memory and sequencer.
// Depends on smft_pkg for payload types, command codes and the state enum.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------
//  term      | in        | term_valid / term_stall     | smft_pkg::term_item_t
//  result    | out       | result_valid / result_stall | smft_pkg::result_item_t
//  cfg       | in        | cfg_we (write only)         | cfg_index, cfg_data
//
// Loads are taken one per cycle, back to back, while idle; the column count is updated by a
// read-modify-write on the count memory with forwarding from the last write.
// A finish run does a prefix walk over the count memory, then placement and then
// emission of the n terms, through chained reads of the term and column memories;
// result stalls add to the emission part.
// Reset clears control state and count valid bits; memories are not cleared.
// term_stall is high for the whole finish run.
module sparse_matrix_fast_transpose_unit #(
    parameter int MAX_TERMS   = smft_pkg::MAX_TERMS_DEF,
    parameter int MAX_DIM     = smft_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = smft_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        term_valid,
    output logic                        term_stall,
    input  smft_pkg::term_item_t        term_item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output smft_pkg::result_item_t      result_item,
    input  logic                        cfg_we,
    input  smft_pkg::cfg_reg_t          cfg_index,
    input  logic [smft_pkg::CFG_W-1:0]  cfg_data
);
    import smft_pkg::*;

    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int TERM_AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int PW        = $clog2(MAX_DIM + 1);
    localparam int VSW       = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int FW        = VSW + 2 * DIM_W;
    localparam int EW        = (FW > TERM_AW) ? FW : TERM_AW;
    localparam int MEM_DEPTH = 2 * MAX_TERMS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Field positions in a term memory word
    localparam int COL_LO = VSW;
    localparam int ROW_LO = VSW + DIM_W;

    // Term memory: terms in the lower half, placement order in the upper half
    logic [EW-1:0]     tm_mem [MEM_DEPTH];
    logic [EW-1:0]     tm_rdata_reg;
    // Column memory: counts, then start positions during the finish run
    logic [CNT_W-1:0]  cm_mem [MAX_DIM];
    logic [CNT_W-1:0]  cm_rdata_reg;
    logic              cm_rvld_reg;
    logic [MAX_DIM-1:0] cnt_vld_reg;

    fst_t               state_reg, state_next;
    logic [CFG_W-1:0]   num_rows_reg, num_cols_reg;
    logic [CNT_W-1:0]   loaded_reg;
    logic               drop_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [PW-1:0]      col_idx_reg;
    logic [CNT_W-1:0]   acc_reg;
    logic               pf_vld_reg;
    logic [DIM_W-1:0]   pf_col_reg;
    logic [DIM_W-1:0]   pl_col_reg;
    logic               cp_vld_reg;
    logic [DIM_W-1:0]   cp_col_reg;
    logic               lw_vld_reg;
    logic [DIM_W-1:0]   lw_col_reg;
    logic [CNT_W-1:0]   lw_cnt_reg;
    logic               out_valid_reg;
    result_item_t       out_item_reg;

    logic               term_fire, is_load, is_finish, load_ok;
    logic               out_free, last_term, pfx_done, clear_run;
    logic [CNT_W-1:0]   cnt_base, cnt_inc, cm_rd_val;
    logic [DIM_W-1:0]   rd_col, rd_row;
    logic [VSW-1:0]     rd_val;

    logic               tm_we, tm_re;
    logic [MEM_AW-1:0]  tm_waddr, tm_raddr;
    logic [EW-1:0]      tm_wdata;
    logic               cm_we, cm_re;
    logic [DIM_W-1:0]   cm_waddr, cm_raddr;
    logic [CNT_W-1:0]   cm_wdata;
    logic               out_load;
    result_item_t       out_item_next;

    // Input transfer decode and bounds check
    assign term_stall = (state_reg != ST_IDLE);
    assign term_fire  = term_valid && !term_stall;
    assign is_load    = term_fire && (term_item.cmd == CMD_LOAD);
    assign is_finish  = term_fire && (term_item.cmd == CMD_FINISH);
    assign load_ok    = (loaded_reg < CNT_W'(MAX_TERMS))
                     && ({1'b0, term_item.src_row} < num_rows_reg)
                     && ({1'b0, term_item.src_col} < num_cols_reg)
                     && ({1'b0, term_item.src_row} < CFG_W'(MAX_DIM))
                     && ({1'b0, term_item.src_col} < CFG_W'(MAX_DIM));

    // Read word fields
    assign rd_val = tm_rdata_reg[VSW-1:0];
    assign rd_col = tm_rdata_reg[COL_LO +: DIM_W];
    assign rd_row = tm_rdata_reg[ROW_LO +: DIM_W];

    // Count update with forwarding from the write of the previous cycle
    assign cm_rd_val = cm_rvld_reg ? cm_rdata_reg : '0;
    assign cnt_base  = (lw_vld_reg && (lw_col_reg == cp_col_reg)) ? lw_cnt_reg : cm_rd_val;
    assign cnt_inc   = cnt_base + 1'b1;

    assign out_free  = !out_valid_reg || !result_stall;
    assign last_term = (CNT_W'(idx_reg + 1'b1) == loaded_reg);
    assign pfx_done  = (col_idx_reg == PW'(MAX_DIM)) && !pf_vld_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_finish)
                begin
                    state_next = (loaded_reg == '0) ? ST_EMPTY : ST_PFX;
                end
            end
            ST_PFX:     if (pfx_done) state_next = ST_PL_TERM;
            ST_PL_TERM: state_next = ST_PL_COL;
            ST_PL_COL:  state_next = ST_PL_WR;
            ST_PL_WR:   state_next = last_term ? ST_EM_ORD : ST_PL_TERM;
            ST_EM_ORD:  state_next = ST_EM_TERM;
            ST_EM_TERM: state_next = ST_EM_OUT;
            ST_EM_OUT:
            begin
                if (out_free)
                begin
                    state_next = last_term ? ST_IDLE : ST_EM_ORD;
                end
            end
            ST_EMPTY:   if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory controls and result loading
    always_comb
    begin
        tm_we         = 1'b0;
        tm_waddr      = MEM_AW'(loaded_reg[TERM_AW-1:0]);
        tm_wdata      = EW'({term_item.src_row[DIM_W-1:0], term_item.src_col[DIM_W-1:0],
                             term_item.term_value[VSW-1:0]});
        tm_re         = 1'b0;
        tm_raddr      = MEM_AW'(idx_reg[TERM_AW-1:0]);
        cm_we         = 1'b0;
        cm_waddr      = cp_col_reg;
        cm_wdata      = cnt_inc;
        cm_re         = 1'b0;
        cm_raddr      = term_item.src_col[DIM_W-1:0];
        out_load      = 1'b0;
        clear_run     = 1'b0;
        out_item_next.out_row    = IDX_W'(rd_col);
        out_item_next.out_col    = IDX_W'(rd_row);
        out_item_next.out_value  = VALUE_W'($signed(rd_val));
        out_item_next.has_term   = 1'b1;
        out_item_next.is_last    = last_term;
        out_item_next.term_count = COUNT_W'(loaded_reg);
        out_item_next.dropped    = drop_reg;

        // count write-back of the load in the previous cycle
        if (cp_vld_reg)
        begin
            cm_we = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (is_load && load_ok)
                begin
                    tm_we = 1'b1;
                    cm_re = 1'b1;
                end
            end
            ST_PFX:
            begin
                cm_raddr = col_idx_reg[DIM_W-1:0];
                cm_re    = (col_idx_reg < PW'(MAX_DIM));
                if (pf_vld_reg)
                begin
                    cm_we    = 1'b1;
                    cm_waddr = pf_col_reg;
                    cm_wdata = acc_reg;
                end
            end
            ST_PL_TERM:
            begin
                tm_re = 1'b1;
            end
            ST_PL_COL:
            begin
                cm_re    = 1'b1;
                cm_raddr = rd_col;
            end
            ST_PL_WR:
            begin
                tm_we    = 1'b1;
                tm_waddr = MEM_AW'(MAX_TERMS) + MEM_AW'(cm_rd_val[TERM_AW-1:0]);
                tm_wdata = EW'(idx_reg[TERM_AW-1:0]);
                cm_we    = 1'b1;
                cm_waddr = pl_col_reg;
                cm_wdata = cm_rd_val + 1'b1;
            end
            ST_EM_ORD:
            begin
                tm_re    = 1'b1;
                tm_raddr = MEM_AW'(MAX_TERMS) + MEM_AW'(idx_reg[TERM_AW-1:0]);
            end
            ST_EM_TERM:
            begin
                tm_re    = 1'b1;
                tm_raddr = MEM_AW'(tm_rdata_reg[TERM_AW-1:0]);
            end
            ST_EM_OUT:
            begin
                out_load  = out_free;
                clear_run = out_free && last_term;
            end
            ST_EMPTY:
            begin
                out_load                 = out_free;
                clear_run                = out_free;
                out_item_next.out_row    = '0;
                out_item_next.out_col    = '0;
                out_item_next.out_value  = '0;
                out_item_next.has_term   = 1'b0;
                out_item_next.is_last    = 1'b1;
                out_item_next.term_count = '0;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Term memory
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            tm_mem[tm_waddr] <= tm_wdata;
        end
        if (tm_re)
        begin
            tm_rdata_reg <= tm_mem[tm_raddr];
        end
    end

    // Column memory
    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cm_mem[cm_waddr] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_rdata_reg <= cm_mem[cm_raddr];
            cm_rvld_reg  <= cnt_vld_reg[cm_raddr];
        end
    end

    // Count pipeline and forwarding registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_vld_reg <= 1'b0;
            lw_vld_reg <= 1'b0;
        end
        else
        begin
            cp_vld_reg <= is_load && load_ok;
            lw_vld_reg <= cp_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_col_reg <= term_item.src_col[DIM_W-1:0];
        lw_col_reg <= cp_col_reg;
        lw_cnt_reg <= cnt_inc;
        pf_col_reg <= col_idx_reg[DIM_W-1:0];
        if (state_reg == ST_PL_COL)
        begin
            pl_col_reg <= rd_col;
        end
    end

    // Sequencer state, counters, flags and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            num_rows_reg <= SIZE_RESET;
            num_cols_reg <= SIZE_RESET;
            loaded_reg   <= '0;
            drop_reg     <= 1'b0;
            idx_reg      <= '0;
            col_idx_reg  <= '0;
            acc_reg      <= '0;
            pf_vld_reg   <= 1'b0;
            cnt_vld_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pf_vld_reg <= (state_reg == ST_PFX) && (col_idx_reg < PW'(MAX_DIM));

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                    CFG_NUM_COLS: num_cols_reg <= cfg_data;
                    default:      num_rows_reg <= num_rows_reg;
                endcase
            end

            if (clear_run)
            begin
                loaded_reg  <= '0;
                drop_reg    <= 1'b0;
                cnt_vld_reg <= '0;
            end
            else
            begin
                if (is_load && load_ok)
                begin
                    loaded_reg <= loaded_reg + 1'b1;
                end
                if (is_load && !load_ok)
                begin
                    drop_reg <= 1'b1;
                end
                if (cm_we)
                begin
                    cnt_vld_reg[cm_waddr] <= 1'b1;
                end
            end

            // walk counters of the finish run
            if (is_finish)
            begin
                idx_reg     <= '0;
                col_idx_reg <= '0;
                acc_reg     <= '0;
            end
            else
            begin
                if ((state_reg == ST_PFX) && (col_idx_reg < PW'(MAX_DIM)))
                begin
                    col_idx_reg <= col_idx_reg + 1'b1;
                end
                if ((state_reg == ST_PFX) && pf_vld_reg)
                begin
                    acc_reg <= acc_reg + cm_rd_val;
                end
                if (state_reg == ST_PL_WR)
                begin
                    idx_reg <= last_term ? '0 : CNT_W'(idx_reg + 1'b1);
                end
                if ((state_reg == ST_EM_OUT) && out_free)
                begin
                    idx_reg <= CNT_W'(idx_reg + 1'b1);
                end
            end
        end
    end

    // Result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

FILE: test/sparse_matrix_fast_transpose_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_matrix_fast_transpose_unit: directed and random term
// loads, transpose predicted in the bench, results checked in order. Depends on smft_pkg.
module sparse_matrix_fast_transpose_unit_tb;
    import smft_pkg::*;

    localparam int CAPACITY        = MAX_TERMS_DEF;
    localparam int DIM             = MAX_DIM_DEF;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 28;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             term_valid   = 1'b0;
    logic             term_stall;
    term_item_t       term_item    = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_item_t     result_item;
    logic             cfg_we       = 1'b0;
    cfg_reg_t         cfg_index    = CFG_NUM_ROWS;
    logic [CFG_W-1:0] cfg_data     = '0;

    // Bench copy of the term store and the size registers
    logic [IDX_W-1:0]          held_rows   [CAPACITY];
    logic [IDX_W-1:0]          held_cols   [CAPACITY];
    logic signed [VALUE_W-1:0] held_values [CAPACITY];
    int                        held_count   = 0;
    logic                      held_dropped = 1'b0;
    logic [CFG_W-1:0]          rows_limit   = SIZE_RESET;
    logic [CFG_W-1:0]          cols_limit   = SIZE_RESET;

    result_item_t expected_transposed[$];

    int mismatches    = 0;
    int sent_items    = 0;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    sparse_matrix_fast_transpose_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .term_valid   (term_valid),
        .term_stall   (term_stall),
        .term_item    (term_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Append a term, or drop it when full or outside the configured size
    function automatic void store_term(term_item_t t);
        if (held_count >= CAPACITY || {1'b0, t.src_row} >= rows_limit
            || {1'b0, t.src_col} >= cols_limit)
            held_dropped = 1'b1;
        else
        begin
            held_rows[held_count]   = t.src_row;
            held_cols[held_count]   = t.src_col;
            held_values[held_count] = t.term_value;
            held_count++;
        end
    endfunction

    // Transposed list: by source column, load order within a column
    function automatic void transpose_store();
        result_item_t res;
        int           k;
        k   = 0;
        res = '0;
        if (held_count == 0)
        begin
            res.is_last = 1'b1;
            res.dropped = held_dropped;
            expected_transposed.push_back(res);
        end
        else
        begin
            for (int col = 0; col < DIM; col++)
                for (int i = 0; i < held_count; i++)
                    if (int'(held_cols[i]) == col)
                    begin
                        res.out_row    = held_cols[i];
                        res.out_col    = held_rows[i];
                        res.out_value  = held_values[i];
                        res.has_term   = 1'b1;
                        res.is_last    = (k == held_count - 1);
                        res.term_count = COUNT_W'(held_count);
                        res.dropped    = held_dropped;
                        expected_transposed.push_back(res);
                        k++;
                    end
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // Track register writes and accepted term transfers
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            if (cfg_index == CFG_NUM_ROWS)
                rows_limit = cfg_data;
            else
                cols_limit = cfg_data;
        end
        if (rst_n && term_valid && !term_stall)
        begin
            if (term_item.cmd == CMD_FINISH)
                transpose_store();
            else
                store_term(term_item);
        end
    end

    task automatic compare_field(string name, logic signed [31:0] want,
                                 logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Check each result transfer against the oldest expected term
    always @(posedge clk)
    begin : check_result
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_transposed.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %p", $time, result_item);
                mismatches++;
            end
            else
            begin
                want = expected_transposed.pop_front();
                compare_field("out_row", 32'(want.out_row), 32'(result_item.out_row));
                compare_field("out_col", 32'(want.out_col), 32'(result_item.out_col));
                compare_field("out_value", 32'(want.out_value),
                              32'(result_item.out_value));
                compare_field("has_term", 32'(want.has_term), 32'(result_item.has_term));
                compare_field("is_last", 32'(want.is_last), 32'(result_item.is_last));
                compare_field("term_count", 32'(want.term_count),
                              32'(result_item.term_count));
                compare_field("dropped", 32'(want.dropped), 32'(result_item.dropped));
            end
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((term_valid && !term_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one item, with an optional idle gap first, and wait for the transfer
    task automatic send_term(term_item_t item);
        int gap;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            term_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        term_valid <= 1'b1;
        term_item  <= item;
        do
            @(posedge clk);
        while (term_stall);
        sent_items++;
    endtask

    task automatic send_load(int r, int c, int v);
        term_item_t t;
        t.cmd        = CMD_LOAD;
        t.src_row    = IDX_W'(r);
        t.src_col    = IDX_W'(c);
        t.term_value = VALUE_W'(v);
        send_term(t);
    endtask

    // Finish item; its other fields are don't-care and get random bits
    task automatic send_finish();
        term_item_t t;
        t.cmd        = CMD_FINISH;
        t.src_row    = IDX_W'($urandom_range(0, 63));
        t.src_col    = IDX_W'($urandom_range(0, 63));
        t.term_value = VALUE_W'($urandom_range(0, 65535));
        send_term(t);
    endtask

    // Mostly in-size indices, sometimes anywhere in the field range
    task automatic send_random_load();
        int r;
        int c;
        if (rows_limit != 0 && $urandom_range(0, 99) < 85)
            r = $urandom_range(0, (rows_limit > DIM ? DIM : rows_limit) - 1);
        else
            r = $urandom_range(0, 63);
        if (cols_limit != 0 && $urandom_range(0, 99) < 85)
            c = $urandom_range(0, (cols_limit > DIM ? DIM : cols_limit) - 1);
        else
            c = $urandom_range(0, 63);
        send_load(r, c, $urandom_range(0, 65535));
    endtask

    // Let all expected results arrive, then give the block time to settle
    task automatic wait_for_drain();
        term_valid <= 1'b0;
        @(posedge clk);
        while (expected_transposed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(int rows, int cols);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= CFG_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= CFG_W'(cols);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Loads followed by a finish; mostly short lists, rarely past capacity
    task automatic run_batch();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            n = $urandom_range(0, 10);
        else if (pick < 95)
            n = $urandom_range(11, 40);
        else
            n = $urandom_range(60, 70);
        repeat (n) send_random_load();
        send_finish();
    endtask

    task automatic test_empty_matrix();
        send_finish();
    endtask

    // Field extremes, several terms sharing a column to show stable order
    task automatic test_field_extremes();
        send_load(0, 0, -32768);
        send_load(63, 63, 32767);
        send_load(0, 63, -1);
        send_load(63, 0, 1);
        send_load(5, 63, 0);
        send_load(42, 0, 21845);
        send_finish();
    endtask

    // Out-of-size drops, zero size, oversize register values
    task automatic test_size_limits();
        write_sizes(5, 7);
        send_load(4, 6, 100);
        send_load(5, 0, 200);
        send_load(0, 7, 300);
        send_load(63, 63, 400);
        send_finish();
        write_sizes(0, 0);
        send_load(0, 0, 1);
        send_finish();
        write_sizes(127, 127);
        send_load(63, 63, -2);
        send_finish();
    endtask

    // Size change with terms already held
    task automatic test_write_between_loads();
        write_sizes(64, 64);
        send_load(10, 3, 7);
        write_sizes(8, 64);
        send_load(10, 4, 8);
        send_load(7, 4, 9);
        send_finish();
    endtask

    task automatic test_store_full();
        write_sizes(64, 64);
        repeat (CAPACITY + 2) send_random_load();
        send_finish();
    endtask

    task automatic run_phase(int gap, int stall, int rows, int cols);
        int stop_at;
        write_sizes(rows, cols);
        send_gap_pct = gap;
        stall_pct    = stall;
        stop_at      = sent_items + PHASE_ITEMS;
        while (sent_items < stop_at)
        begin
            if ($urandom_range(0, 99) < 15)
                write_sizes($urandom_range(1, 64), $urandom_range(1, 64));
            run_batch();
        end
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 64, 64);
        run_phase(48, 0, 1, 64);
        run_phase(0, 48, 64, 1);
        run_phase(23, 23, $urandom_range(1, 64), $urandom_range(1, 64));
    endtask

    // Receiver holds off while the sender keeps offering terms
    task automatic test_hold_off();
        write_sizes(64, 64);
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (30) send_random_load();
        send_finish();
        repeat (20) send_random_load();
        send_finish();
        repeat (5) send_random_load();
        send_finish();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_matrix();
        test_field_extremes();
        test_size_limits();
        test_write_between_loads();
        test_store_full();
        test_random_traffic();
        test_hold_off();
        wait_for_drain();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
